// ===== hw/rtl/lsb_stego_extract_unit_macros.svh =====
// ---------------------------------------------------------------------------
// lsb_stego_extract_unit assertion macros
// shared concurrent assertion forms, clocked on aclk
// ---------------------------------------------------------------------------
`ifndef LSB_STEGO_EXTRACT_UNIT_MACROS_SVH
`define LSB_STEGO_EXTRACT_UNIT_MACROS_SVH

// check a property outside reset
`define LSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// check a property on every edge, reset included
`define LSE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/lse_pkg.sv =====
// ---------------------------------------------------------------------------
// lse_pkg
// shared types and constants of the lsb stego extraction unit
// ---------------------------------------------------------------------------
package lse_pkg;

    // field widths
    localparam int PIXELS_W        = 24;
    localparam int CHAN_W          = 8;
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 2;
    localparam int HEADER_BITS_DEF = 16;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_SMALL    = 2'd2,
        KIND_CAPACITY = 2'd3
    } kind_t;

    // decoder phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    // one input pixel
    typedef struct packed {
        logic              start;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // one result
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

    // result handoff from decoder to output buffer
    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

endpackage

// ===== hw/rtl/lse_decode.sv =====
// ---------------------------------------------------------------------------
// lse_decode
// hidden bit recovery, header length capture and payload byte packing
// ---------------------------------------------------------------------------
`include "lsb_stego_extract_unit_macros.svh"

module lse_decode #(
    parameter int HEADER_BITS = lse_pkg::HEADER_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  lse_pkg::pixel_t               pixel,
    input  logic [lse_pkg::PIXELS_W-1:0]  image_pixels,
    output lse_pkg::push_t                push
);

    localparam int CNT_W = $clog2(HEADER_BITS + 1);
    localparam int CMP_W = (HEADER_BITS + 3 > lse_pkg::PIXELS_W) ?
                           HEADER_BITS + 3 : lse_pkg::PIXELS_W;

    lse_pkg::phase_t            phase_reg,  phase_next;
    logic [HEADER_BITS-1:0]     length_reg, length_next;
    logic [CNT_W-1:0]           count_reg,  count_next;
    logic [lse_pkg::BYTE_W-1:0] byte_reg,   byte_next;
    logic [HEADER_BITS-1:0]     left_reg,   left_next;

    logic                          hbit;
    logic [lse_pkg::PIXELS_W-1:0]  avail;
    logic [CMP_W-1:0]              needed;
    logic [CNT_W-1:0]              cnt_inc;

    assign hbit = pixel.green[0] ^ pixel.blue[0];

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= lse_pkg::PH_IDLE;
            length_reg <= '0;
            count_reg  <= '0;
            byte_reg   <= '0;
            left_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            byte_reg   <= byte_next;
            left_reg   <= left_next;
        end
    end

    // next state and result for the pixel in the input register
    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        byte_next   = byte_reg;
        left_next   = left_reg;
        push.valid    = 1'b0;
        push.res.kind = lse_pkg::KIND_BYTE;
        push.res.data = '0;
        push.res.last = 1'b0;
        avail   = '0;
        needed  = '0;
        cnt_inc = '0;

        // start of image drops partial work
        if (pixel.start) begin
            length_next = '0;
            count_next  = '0;
            byte_next   = '0;
            left_next   = '0;
            if (image_pixels < lse_pkg::PIXELS_W'(HEADER_BITS)) begin
                phase_next    = lse_pkg::PH_IDLE;
                push.valid    = step;
                push.res.kind = lse_pkg::KIND_SMALL;
                push.res.last = 1'b1;
            end else begin
                phase_next = lse_pkg::PH_HEADER;
            end
        end

        if (!(pixel.start && image_pixels < lse_pkg::PIXELS_W'(HEADER_BITS))) begin
            cnt_inc = count_next + CNT_W'(1);
            unique case (phase_next)
                // collect length bits, msb first
                lse_pkg::PH_HEADER: begin
                    length_next = {length_next[HEADER_BITS-2:0], hbit};
                    count_next  = cnt_inc;
                    if (cnt_inc >= CNT_W'(HEADER_BITS)) begin
                        needed = CMP_W'({length_next, 3'b000});
                        if (image_pixels > lse_pkg::PIXELS_W'(HEADER_BITS)) begin
                            avail = image_pixels - lse_pkg::PIXELS_W'(HEADER_BITS);
                        end
                        phase_next = lse_pkg::PH_IDLE;
                        if (needed > CMP_W'(avail)) begin
                            push.valid    = step;
                            push.res.kind = lse_pkg::KIND_CAPACITY;
                            push.res.last = 1'b1;
                        end else if (length_next == '0) begin
                            push.valid    = step;
                            push.res.kind = lse_pkg::KIND_DONE;
                            push.res.last = 1'b1;
                        end else begin
                            phase_next = lse_pkg::PH_PAYLOAD;
                            left_next  = length_next;
                            count_next = '0;
                            byte_next  = '0;
                        end
                    end
                end
                // pack payload bits, msb first
                lse_pkg::PH_PAYLOAD: begin
                    byte_next  = {byte_next[lse_pkg::BYTE_W-2:0], hbit};
                    count_next = cnt_inc;
                    if (cnt_inc >= CNT_W'(lse_pkg::BYTE_W)) begin
                        push.valid    = step;
                        push.res.kind = lse_pkg::KIND_BYTE;
                        push.res.data = byte_next;
                        push.res.last = (left_next <= HEADER_BITS'(1));
                        count_next    = '0;
                        byte_next     = '0;
                        if (left_next <= HEADER_BITS'(1)) begin
                            phase_next = lse_pkg::PH_IDLE;
                        end
                        left_next = left_next - HEADER_BITS'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `LSE_ASSERT(a_err_kinds_last, push.valid && push.res.kind != lse_pkg::KIND_BYTE |-> push.res.last && push.res.data == '0, "non-byte result must be last and zero")
    `LSE_ASSERT(a_payload_left, phase_reg == lse_pkg::PH_PAYLOAD |-> left_reg != '0, "payload phase with no bytes left")
    `LSE_ASSERT(a_count_range, phase_reg == lse_pkg::PH_PAYLOAD |-> count_reg < CNT_W'(lse_pkg::BYTE_W), "payload bit count out of range")

endmodule

// ===== hw/rtl/lse_out_buf.sv =====
// ---------------------------------------------------------------------------
// lse_out_buf
// result register with skid stage toward the master channel
// ---------------------------------------------------------------------------
`include "lsb_stego_extract_unit_macros.svh"

module lse_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  lse_pkg::push_t   push,
    output logic             space,
    output logic             out_valid,
    output lse_pkg::result_t out_res,
    input  logic             out_ready
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    lse_pkg::result_t main_reg;
    lse_pkg::result_t skid_reg;
    logic             pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push.valid) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push.valid) begin
            if (main_valid_reg && !pop) begin
                skid_reg <= push.res;
            end else begin
                main_reg <= push.res;
            end
        end
    end

    `LSE_ASSERT(a_skid_implies_main, skid_valid_reg |-> main_valid_reg, "skid full with empty main")
    `LSE_ASSERT(a_no_push_when_full, push.valid |-> !skid_valid_reg, "result pushed into full buffer")
    `LSE_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !main_valid_reg && !skid_valid_reg, "buffer not empty after reset")

endmodule

// ===== hw/rtl/lsb_stego_extract_unit.sv =====
// ---------------------------------------------------------------------------
// lsb_stego_extract_unit
// recovers a length-prefixed payload from the low bits of image pixels
// ---------------------------------------------------------------------------
// usage:
//   s_ channel: one pixel per beat, tuser marks the first pixel of an image,
//   tdata carries green and blue bytes. each pixel gives one hidden bit.
//   m_ channel: at most one result per pixel: a payload byte every eight
//   payload pixels, or a done / too-small / over-capacity code. tlast flags
//   the final result of an image.
//   cfg_wr_en / cfg_wr_data load the image pixel count; write it while idle.
//   path: the input register loads the pixel beat, the decoder works on it
//   combinationally, and the result register (or skid stage) loads the result.
//   throughput: one pixel per cycle while the skid stage is empty, set by the
//   state update between the input register and the result register.
//   reset: synchronous active-low aresetn empties the input, result and skid
//   registers, clears the decoder to idle and the pixel count to zero.
//   stall: a skid stage holds one extra result; while it is full the input
//   register holds its pixel and s_tready drops once that is occupied.
// ---------------------------------------------------------------------------
module lsb_stego_extract_unit #(
    parameter int HEADER_BITS = lse_pkg::HEADER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [lse_pkg::PIXELS_W-1:0]        cfg_wr_data,
    // pixel input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*lse_pkg::CHAN_W-1:0]        s_tdata,   // green_value, blue_value
    input  logic                                s_tuser,   // start_of_image
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lse_pkg::BYTE_W-1:0]          m_tdata,   // payload_byte
    output logic [lse_pkg::KIND_W-1:0]          m_tuser,   // result_kind
    output logic                                m_tlast    // last_byte
);

    logic [lse_pkg::PIXELS_W-1:0] pixels_reg;
    logic                         in_valid_reg;
    lse_pkg::pixel_t              in_reg;
    logic                         space;
    logic                         advance;
    logic                         s_accept;
    lse_pkg::push_t               push;
    lse_pkg::result_t             out_res;

    assign advance  = in_valid_reg && space;
    assign s_tready = !in_valid_reg || space;
    assign s_accept = s_tvalid && s_tready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixels_reg <= '0;
        end else if (cfg_wr_en) begin
            pixels_reg <= cfg_wr_data;
        end
    end

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg.start <= s_tuser;
            in_reg.green <= s_tdata[lse_pkg::CHAN_W-1:0];
            in_reg.blue  <= s_tdata[2*lse_pkg::CHAN_W-1:lse_pkg::CHAN_W];
        end
    end

    lse_decode #(
        .HEADER_BITS (HEADER_BITS)
    ) u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .pixel        (in_reg),
        .image_pixels (pixels_reg),
        .push         (push)
    );

    lse_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space     (space),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    // result fields onto the master channel
    assign m_tdata = out_res.data;
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ===== tb/tb_lsb_stego_extract_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lsb_stego_extract_unit
// self-checking bench: pixels carrying a length header and payload bits are
// streamed in, a local decoder predicts every result, and each result beat
// is compared field by field against the oldest prediction
// ---------------------------------------------------------------------------
module tb_lsb_stego_extract_unit;

    localparam int HDR         = lse_pkg::HEADER_BITS_DEF;
    localparam int PIX_W       = lse_pkg::PIXELS_W;
    localparam int SETTLE_CYC  = 6;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PIX  = 700;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [PIX_W-1:0]                  cfg_wr_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [2*lse_pkg::CHAN_W-1:0]      s_tdata;    // green_value, blue_value
    logic                              s_tuser;    // start_of_image
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [lse_pkg::BYTE_W-1:0]        m_tdata;    // payload_byte
    logic [lse_pkg::KIND_W-1:0]        m_tuser;    // result_kind
    logic                              m_tlast;    // last_byte

    // decoder mirror
    lse_pkg::phase_t     dec_phase   = lse_pkg::PH_IDLE;
    logic [HDR-1:0]      hdr_len     = '0;
    logic [5:0]          bits_taken  = '0;
    logic [7:0]          byte_acc    = '0;
    logic [HDR-1:0]      bytes_to_go = '0;
    logic [PIX_W-1:0]    img_pixels  = '0;
    lse_pkg::result_t    pending_results[$];

    int               mismatches  = 0;
    int               pixels_sent = 0;
    int               cycle_count = 0;
    int               gap_pct     = 0;
    int               stall_pct   = 0;
    int               stall_left  = 0;
    int               hold_cycles = 0;
    lse_pkg::result_t got_want;

    lsb_stego_extract_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #1 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic void queue_result(lse_pkg::kind_t k, logic [7:0] d, logic l);
        lse_pkg::result_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        pending_results.push_back(r);
    endfunction

    // advance the decoder mirror by one accepted pixel
    task automatic decode_pixel(input logic sof, input logic [7:0] g, input logic [7:0] b);
        logic   hb;
        logic   is_last;
        longint needed;
        longint avail;
        hb = g[0] ^ b[0];
        if (sof) begin
            hdr_len     = '0;
            bits_taken  = '0;
            byte_acc    = '0;
            bytes_to_go = '0;
            if (img_pixels < HDR) begin
                dec_phase = lse_pkg::PH_IDLE;
                queue_result(lse_pkg::KIND_SMALL, 8'h00, 1'b1);
            end else begin
                dec_phase = lse_pkg::PH_HEADER;
            end
        end
        case (dec_phase)
            lse_pkg::PH_HEADER: begin
                hdr_len    = {hdr_len[HDR-2:0], hb};
                bits_taken = bits_taken + 1'b1;
                if (bits_taken >= HDR) begin
                    needed    = longint'(hdr_len) * 8;
                    avail     = (img_pixels > HDR) ? longint'(img_pixels) - HDR : 0;
                    dec_phase = lse_pkg::PH_IDLE;
                    if (needed > avail) begin
                        queue_result(lse_pkg::KIND_CAPACITY, 8'h00, 1'b1);
                    end else if (hdr_len == '0) begin
                        queue_result(lse_pkg::KIND_DONE, 8'h00, 1'b1);
                    end else begin
                        dec_phase   = lse_pkg::PH_PAYLOAD;
                        bytes_to_go = hdr_len;
                        bits_taken  = '0;
                        byte_acc    = '0;
                    end
                end
            end
            lse_pkg::PH_PAYLOAD: begin
                byte_acc   = {byte_acc[6:0], hb};
                bits_taken = bits_taken + 1'b1;
                if (bits_taken >= 8) begin
                    is_last = (bytes_to_go <= 1);
                    queue_result(lse_pkg::KIND_BYTE, byte_acc, is_last);
                    bits_taken  = '0;
                    byte_acc    = '0;
                    bytes_to_go = bytes_to_go - 1'b1;
                    if (is_last) begin
                        dec_phase = lse_pkg::PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // one pixel beat; entered and left on a falling edge
    task automatic send_pixel(input logic sof, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sof;
        s_tdata  <= {b, g};
        do @(posedge aclk); while (!s_tready);
        decode_pixel(sof, g, b);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // random pixel whose hidden bit is hb
    task automatic send_bit(input logic sof, input logic hb);
        logic [7:0] g;
        logic [7:0] b;
        g    = 8'($urandom_range(255));
        b    = 8'($urandom_range(255));
        b[0] = g[0] ^ hb;
        send_pixel(sof, g, b);
    endtask

    task automatic send_header(input logic [HDR-1:0] len);
        for (int i = HDR - 1; i >= 0; i--) begin
            send_bit(i == HDR - 1, len[i]);
        end
    endtask

    task automatic send_byte(input logic [7:0] value);
        for (int i = 7; i >= 0; i--) begin
            send_bit(1'b0, value[i]);
        end
    endtask

    task automatic send_noise(input int n, input int sof_pct);
        for (int i = 0; i < n; i++) begin
            send_pixel($urandom_range(99) < sof_pct, 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        end
    endtask

    // stop sending and let every outstanding result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    task automatic write_image_pixels(input logic [PIX_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        img_pixels = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // start pixels on images below the header size, idle pixels ignored
    task automatic test_small_image();
        write_image_pixels('0);
        send_pixel(1'b0, 8'h00, 8'h00);
        send_pixel(1'b0, 8'hFF, 8'hFF);
        send_pixel(1'b1, 8'h00, 8'hFF);
        send_pixel(1'b1, 8'hFF, 8'h00);
        write_image_pixels(PIX_W'(HDR - 1));
        send_bit(1'b1, 1'b1);
        send_pixel(1'b0, 8'hFF, 8'h00);
    endtask

    // zero length header gives a done code, trailing pixels ignored
    task automatic test_empty_payload();
        write_image_pixels(PIX_W'(HDR));
        send_header('0);
        send_noise(3, 0);
    endtask

    // length that does not fit, including the largest length
    task automatic test_capacity();
        write_image_pixels(PIX_W'(HDR + 8 * 3 - 1));
        send_header(HDR'(3));
        write_image_pixels(PIX_W'(100));
        send_header('1);
    endtask

    // two byte payload at the byte extremes, exact fit
    task automatic test_payload();
        write_image_pixels(PIX_W'(HDR + 8 * 2));
        send_header(HDR'(2));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_noise(4, 0);
    endtask

    // start pixel in mid header and in mid payload drops partial work
    task automatic test_restart();
        write_image_pixels('1);
        for (int i = 0; i < 5; i++) begin
            send_bit(i == 0, 1'b1);
        end
        send_header('1);
        send_byte(8'hA5);
        send_byte(8'h3C);
        for (int i = 0; i < 4; i++) begin
            send_bit(1'b0, i[0]);
        end
        send_header(HDR'(1));
        send_byte(8'h81);
        send_noise(2, 0);
    endtask

    // long receiver hold while pixels keep coming, fills the block
    task automatic test_backpressure();
        write_image_pixels(PIX_W'(HDR + 8 * 40));
        gap_pct   = 0;
        stall_pct = 0;
        send_header(HDR'(40));
        hold_cycles <= 300;
        for (int i = 0; i < 40; i++) begin
            send_byte(8'($urandom_range(255)));
        end
        settle();
    endtask

    // mostly well formed images with random content, some broken ones
    task automatic test_random();
        int target;
        int cap;
        int len;
        int r;
        int nbits;
        target = pixels_sent + RANDOM_PIX;
        while (pixels_sent < target) begin
            r         = $urandom_range(2);
            gap_pct   = (r == 0) ? 0 : (r == 1) ? 10 : 40;
            r         = $urandom_range(2);
            stall_pct = (r == 0) ? 0 : (r == 1) ? 10 : 40;
            if ($urandom_range(99) < 15) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    write_image_pixels(PIX_W'(HDR + 8 * $urandom_range(12)
                                              + $urandom_range(15)));
                end else if (r < 75) begin
                    write_image_pixels(PIX_W'($urandom_range(HDR - 1)));
                end else if (r < 85) begin
                    write_image_pixels('1);
                end else begin
                    write_image_pixels(PIX_W'($urandom_range(24'hFFFFFF)));
                end
            end
            cap = (img_pixels >= HDR) ? (int'(img_pixels) - HDR) / 8 : 0;
            r   = $urandom_range(99);
            if (r < 65 || (r < 75 && cap >= 65535)) begin
                len = $urandom_range((cap < 12) ? cap : 12);
                send_header(HDR'(len));
                for (int i = 0; i < len; i++) begin
                    send_byte(8'($urandom_range(255)));
                end
                send_noise($urandom_range(10), 0);
            end else if (r < 75) begin
                len = cap + 1 + $urandom_range((65534 - cap < 200) ? 65534 - cap : 200);
                send_header(HDR'(len));
                send_noise($urandom_range(4), 0);
            end else if (r < 87) begin
                // header cut short, or payload cut short by the next image
                len = (cap < 12) ? cap : 12;
                if (len == 0 || $urandom_range(1) == 0) begin
                    nbits = $urandom_range(HDR - 1, 1);
                    for (int i = 0; i < nbits; i++) begin
                        send_bit(i == 0, 1'($urandom_range(1)));
                    end
                end else begin
                    send_header(HDR'($urandom_range(len, 1)));
                    send_noise($urandom_range(8 * len - 1), 0);
                end
            end else begin
                send_noise($urandom_range(20, 1), 8);
            end
        end
    endtask

    // receiver: random stalls plus a counted hold when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result, actual kind %0d byte %02h last %0b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                got_want = pending_results.pop_front();
                if (m_tuser !== got_want.kind || m_tdata !== got_want.data
                        || m_tlast !== got_want.last) begin
                    mismatches++;
                    $display({"%0t: expected kind %0d byte %02h last %0b,",
                              " actual kind %0d byte %02h last %0b"},
                             $time, got_want.kind, got_want.data, got_want.last,
                             m_tuser, m_tdata, m_tlast);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        gap_pct   = 20;
        stall_pct = 20;
        test_small_image();
        test_empty_payload();
        test_capacity();
        test_payload();
        test_restart();
        test_backpressure();
        test_random();

        settle();
        repeat (10) @(negedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lse_pkg.sv
hw/rtl/lse_decode.sv
hw/rtl/lse_out_buf.sv
hw/rtl/lsb_stego_extract_unit.sv
tb/tb_lsb_stego_extract_unit.sv
